[rtl/dffc_pkg.sv]
// Package for the flat-field correction block: payload types and constants.
// No dependencies; used by every module of the block.
package dffc_pkg;

  localparam int PixelW     = 16;
  localparam int MeanW      = 24;
  localparam int CalibW     = 16;
  localparam int CalibFrac  = 8;
  localparam int CfgDataW   = 24;
  localparam int CfgIndexW  = 3;
  localparam int QueueDepth = 4;
  localparam int DefPixelBits    = 16;
  localparam int DefMeanFracBits = 8;

  // Register indexes of the configuration port
  localparam logic [CfgIndexW-1:0] RegDarkEnable  = 3'd0;
  localparam logic [CfgIndexW-1:0] RegGainEnable  = 3'd1;
  localparam logic [CfgIndexW-1:0] RegDarkLoaded  = 3'd2;
  localparam logic [CfgIndexW-1:0] RegGainLoaded  = 3'd3;
  localparam logic [CfgIndexW-1:0] RegGainMean    = 3'd4;
  localparam logic [CfgIndexW-1:0] RegCalibFactor = 3'd5;
  localparam logic [CfgIndexW-1:0] RegClampEnable = 3'd6;
  localparam logic [CfgIndexW-1:0] RegClampValue  = 3'd7;

  typedef struct packed {
    logic [PixelW-1:0] raw_pixel;
    logic [PixelW-1:0] dark_pixel;
    logic [PixelW-1:0] gain_pixel;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    logic [PixelW-1:0] corrected_pixel;
    logic              saturated;
    logic              frame_last;
  } out_item_t;

  // Configuration as seen by the front and back
  typedef struct packed {
    logic              dark_enable;
    logic              gain_enable;
    logic              dark_loaded;
    logic              gain_loaded;
    logic [MeanW-1:0]  gain_mean;
    logic [CalibW-1:0] calib_factor;
    logic              clamp_enable;
    logic [PixelW-1:0] clamp_value;
  } cfg_t;

endpackage

[rtl/detector_flat_field_correction_top.sv]
// Top level of the flat-field offset and gain correction block.
// Depends on dffc_pkg, dffc_front, dffc_queue and dffc_back.
//
// Usage:
//   Input channel in_valid / in_stall / in_item carries one raw pixel with its
//   dark and gain reference pixels; output channel out_valid / out_stall /
//   out_item returns one corrected pixel per item, in order.
//   Registers are written through cfg_we / cfg_index / cfg_data; the user must do so only while idle (not enforced).
// Throughput: one item per clock; the pixel pipeline advances every cycle
//   in which the output register is empty or being taken.
// Pipeline: front queue, mean product, divider load and PIXEL_BITS divider
//   stages of one quotient bit each, calibration product, output register.
// Reset: synchronous, clears the queue, all pipeline valid bits and the
//   registers to their defaults (calibration factor 1.0, clamp at 65535).
// Receiver stall: the pipeline holds; the four-entry queue fills and then
//   in_stall is raised until room frees up.
module detector_flat_field_correction_top #(
  parameter int PIXEL_BITS     = dffc_pkg::DefPixelBits,
  parameter int MEAN_FRAC_BITS = dffc_pkg::DefMeanFracBits
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dffc_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dffc_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [dffc_pkg::CfgIndexW-1:0]      cfg_index,
  input  logic [dffc_pkg::CfgDataW-1:0]       cfg_data
);

  localparam int EW = 2*PIXEL_BITS + 2;

  dffc_pkg::cfg_t cfg;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dark_enable  <= 1'b0;
      cfg.gain_enable  <= 1'b0;
      cfg.dark_loaded  <= 1'b0;
      cfg.gain_loaded  <= 1'b0;
      cfg.gain_mean    <= '0;
      cfg.calib_factor <= dffc_pkg::CalibW'(256);
      cfg.clamp_enable <= 1'b0;
      cfg.clamp_value  <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dffc_pkg::RegDarkEnable:  cfg.dark_enable  <= cfg_data[0];
        dffc_pkg::RegGainEnable:  cfg.gain_enable  <= cfg_data[0];
        dffc_pkg::RegDarkLoaded:  cfg.dark_loaded  <= cfg_data[0];
        dffc_pkg::RegGainLoaded:  cfg.gain_loaded  <= cfg_data[0];
        dffc_pkg::RegGainMean:    cfg.gain_mean    <= cfg_data[dffc_pkg::MeanW-1:0];
        dffc_pkg::RegCalibFactor: cfg.calib_factor <= cfg_data[dffc_pkg::CalibW-1:0];
        dffc_pkg::RegClampEnable: cfg.clamp_enable <= cfg_data[0];
        dffc_pkg::RegClampValue:  cfg.clamp_value  <= cfg_data[dffc_pkg::PixelW-1:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] f_entry, q_data;
  logic          q_full, q_valid, q_pop, push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  dffc_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
    .item  (in_item),
    .cfg   (cfg),
    .entry (f_entry)
  );

  dffc_queue #(.WIDTH(EW), .DEPTH(dffc_pkg::QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  dffc_back #(.PIXEL_BITS(PIXEL_BITS), .MEAN_FRAC_BITS(MEAN_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

[rtl/dffc_front.sv]
// Front of the flat-field correction: picks the mode and forms numerator and
// denominator of each item. Depends on dffc_pkg.
module dffc_front #(
  parameter int PIXEL_BITS = dffc_pkg::DefPixelBits
) (
  input  dffc_pkg::in_item_t        item,
  input  dffc_pkg::cfg_t            cfg,
  output logic [2*PIXEL_BITS+1:0]   entry
);

  logic [PIXEL_BITS-1:0] r, d, g, num, den, sub;
  logic                  div;

  assign r = item.raw_pixel[PIXEL_BITS-1:0];
  assign d = item.dark_pixel[PIXEL_BITS-1:0];
  assign g = item.gain_pixel[PIXEL_BITS-1:0];
  assign sub = (r > d) ? (r - d) : '0;

  // Classify by the enable modes
  always_comb begin
    div = 1'b0;
    num = r;
    den = g;
    if (cfg.dark_enable && !cfg.gain_enable) begin
      if (cfg.dark_loaded) num = sub;
    end else if (!cfg.dark_enable && cfg.gain_enable) begin
      if (cfg.gain_loaded && g != '0) div = 1'b1;
    end else if (cfg.dark_enable && cfg.gain_enable) begin
      if (cfg.dark_loaded && cfg.gain_loaded) begin
        if (g <= d) begin
          num = sub;
        end else if (r < d) begin
          num = '0;
        end else begin
          div = 1'b1;
          num = r - d;
          den = g - d;
        end
      end
    end
  end

  assign entry = {div, item.frame_end, num, den};

endmodule

[rtl/dffc_queue.sv]
// Short FIFO between front and back of the flat-field correction.
// Depends on dffc_pkg for its default depth.
module dffc_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = dffc_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/dffc_back.sv]
// Back of the flat-field correction: mean product, pipelined restoring
// divider, calibration, saturation, clamp and output register.
// Depends on dffc_pkg.
module dffc_back #(
  parameter int PIXEL_BITS     = dffc_pkg::DefPixelBits,
  parameter int MEAN_FRAC_BITS = dffc_pkg::DefMeanFracBits
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dffc_pkg::cfg_t            cfg,
  input  logic                      q_valid,
  input  logic [2*PIXEL_BITS+1:0]   q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output dffc_pkg::out_item_t       out_item
);

  localparam int PB = PIXEL_BITS;
  localparam int PW = PB + dffc_pkg::MeanW;
  localparam int NW = PW - MEAN_FRAC_BITS;
  localparam int HW = NW - PB;
  localparam int CW = PB + dffc_pkg::CalibW - dffc_pkg::CalibFrac;

  logic adv;
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_valid;

  // Unpack queue entry
  logic                  e_div, e_fe;
  logic [PB-1:0]         e_num, e_den;
  logic [PW-1:0]         e_prod;
  assign {e_div, e_fe, e_num, e_den} = q_data;
  assign e_prod = PW'(e_num) * PW'(cfg.gain_mean);

  // Stage A: product of numerator and mean, scaled down by the fraction bits
  logic          a_valid, a_div, a_fe;
  logic [NW-1:0] a_n;
  logic [PB-1:0] a_v, a_den;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (adv) a_valid <= q_valid;
    if (adv) begin
      a_div <= e_div;
      a_fe  <= e_fe;
      a_v   <= e_num;
      a_den <= e_den;
      a_n   <= e_prod[PW-1:MEAN_FRAC_BITS];
    end
  end

  // Divider stages; index 0 is loaded from stage A
  logic          dv_valid [PB+1];
  logic          dv_div   [PB+1];
  logic          dv_fe    [PB+1];
  logic          dv_sat   [PB+1];
  logic [PB-1:0] dv_v     [PB+1];
  logic [PB-1:0] dv_den   [PB+1];
  logic [PB-1:0] dv_rem   [PB+1];
  logic [PB-1:0] dv_sh    [PB+1];

  logic [PB-1:0] rem_next [PB];
  logic [PB-1:0] sh_next  [PB];

  // Quotient overflow: high part of the dividend not below the divisor
  logic a_over;
  localparam int XW = (HW > PB) ? HW : PB;
  assign a_over = XW'(a_n[NW-1:PB]) >= XW'(a_den);

  // One quotient bit per stage
  always_comb begin
    logic [PB:0] t;
    logic        ge;
    for (int i = 0; i < PB; i++) begin
      t  = {dv_rem[i], dv_sh[i][PB-1]};
      ge = t >= {1'b0, dv_den[i]};
      rem_next[i] = ge ? PB'(t - {1'b0, dv_den[i]}) : t[PB-1:0];
      sh_next[i]  = {dv_sh[i][PB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= PB; i++) dv_valid[i] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= a_valid;
      for (int i = 0; i < PB; i++) dv_valid[i+1] <= dv_valid[i];
    end
    if (adv) begin
      dv_div[0] <= a_div;
      dv_fe[0]  <= a_fe;
      dv_sat[0] <= a_div && a_over;
      dv_v[0]   <= a_v;
      dv_den[0] <= a_den;
      dv_rem[0] <= a_over ? '0 : a_n[NW-1:PB];
      dv_sh[0]  <= a_n[PB-1:0];
      for (int i = 0; i < PB; i++) begin
        dv_div[i+1] <= dv_div[i];
        dv_fe[i+1]  <= dv_fe[i];
        dv_sat[i+1] <= dv_sat[i];
        dv_v[i+1]   <= dv_v[i];
        dv_den[i+1] <= dv_den[i];
        dv_rem[i+1] <= rem_next[i];
        dv_sh[i+1]  <= sh_next[i];
      end
    end
  end

  // Stage C: pick the value and form the calibration product
  logic [PB-1:0] c_sel;
  assign c_sel = !dv_div[PB] ? dv_v[PB] : (dv_sat[PB] ? '1 : dv_sh[PB]);

  logic                                 c_valid, c_fe, c_sat, c_cal;
  logic [PB-1:0]                        c_v;
  logic [PB+dffc_pkg::CalibW-1:0]       c_prod;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (adv) c_valid <= dv_valid[PB];
    if (adv) begin
      c_fe   <= dv_fe[PB];
      c_sat  <= dv_sat[PB];
      c_cal  <= cfg.gain_enable;
      c_v    <= c_sel;
      c_prod <= (PB+dffc_pkg::CalibW)'(c_sel) * (PB+dffc_pkg::CalibW)'(cfg.calib_factor);
    end
  end

  // Calibration saturation and clamp into the output register
  logic [CW-1:0] c_scaled;
  logic          c_over;
  logic [PB-1:0] c_fin;
  logic          c_satf;
  logic [PB-1:0] c_out;
  assign c_scaled = c_prod[PB+dffc_pkg::CalibW-1:dffc_pkg::CalibFrac];
  assign c_over   = c_scaled[CW-1:PB] != '0;
  assign c_fin    = c_cal ? (c_over ? '1 : c_scaled[PB-1:0]) : c_v;
  assign c_satf   = c_sat || (c_cal && c_over);
  assign c_out    = (cfg.clamp_enable && dffc_pkg::PixelW'(c_fin) >= cfg.clamp_value)
                    ? cfg.clamp_value[PB-1:0] : c_fin;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= c_valid;
    if (adv) begin
      out_item.corrected_pixel <= dffc_pkg::PixelW'(c_out);
      out_item.saturated       <= c_satf;
      out_item.frame_last      <= c_fe;
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for detector_flat_field_correction_top.
// Depends on dffc_pkg and the block's RTL; predicts each corrected pixel
// from the register settings and compares results in order.
`timescale 1ns / 1ps

module tb;

  localparam int PixMax = 65535;
  localparam int DW     = dffc_pkg::CfgDataW;

  // Scoreboard: predicts corrected pixels and checks them in order
  class pixel_scoreboard;
    logic                        dark_en, gain_en, dark_ld, gain_ld, clamp_en;
    logic [dffc_pkg::MeanW-1:0]  mean;
    logic [dffc_pkg::CalibW-1:0] calib;
    logic [dffc_pkg::PixelW-1:0] clamp_val;
    dffc_pkg::out_item_t         pending[$];
    int                          errors;

    function void reset_regs();
      dark_en = 0; gain_en = 0; dark_ld = 0; gain_ld = 0; clamp_en = 0;
      mean = 0; calib = 256; clamp_val = 16'hFFFF;
    endfunction

    function void write_reg(logic [dffc_pkg::CfgIndexW-1:0] idx,
                            logic [dffc_pkg::CfgDataW-1:0] val);
      case (idx)
        dffc_pkg::RegDarkEnable:  dark_en = val[0];
        dffc_pkg::RegGainEnable:  gain_en = val[0];
        dffc_pkg::RegDarkLoaded:  dark_ld = val[0];
        dffc_pkg::RegGainLoaded:  gain_ld = val[0];
        dffc_pkg::RegGainMean:    mean = val[dffc_pkg::MeanW-1:0];
        dffc_pkg::RegCalibFactor: calib = val[dffc_pkg::CalibW-1:0];
        dffc_pkg::RegClampEnable: clamp_en = val[0];
        dffc_pkg::RegClampValue:  clamp_val = val[dffc_pkg::PixelW-1:0];
        default: ;
      endcase
    endfunction

    // floor(num * mean / den) with saturation
    function longint unsigned scale_by_mean(longint unsigned num, longint unsigned den,
                                            ref bit sat);
      longint unsigned q;
      q = (num * mean) / (den << 8);
      if (q > PixMax) begin
        sat = 1;
        q = PixMax;
      end
      return q;
    endfunction

    function void note_input(dffc_pkg::in_item_t it);
      longint unsigned r, d, g, v;
      bit sat;
      dffc_pkg::out_item_t exp_item;
      r = it.raw_pixel; d = it.dark_pixel; g = it.gain_pixel;
      v = r; sat = 0;
      if (dark_en && !gain_en) begin
        if (dark_ld) v = (r > d) ? r - d : 0;
      end else if (!dark_en && gain_en) begin
        if (gain_ld && g != 0) v = scale_by_mean(r, g, sat);
      end else if (dark_en && gain_en) begin
        if (dark_ld && gain_ld) begin
          if (g <= d) v = (r > d) ? r - d : 0;
          else if (r < d) v = 0;
          else v = scale_by_mean(r - d, g - d, sat);
        end
      end
      if (gain_en) begin
        v = (v * calib) >> 8;
        if (v > PixMax) begin
          sat = 1;
          v = PixMax;
        end
      end
      if (clamp_en && v >= clamp_val) v = clamp_val;
      exp_item.corrected_pixel = v[15:0];
      exp_item.saturated = sat;
      exp_item.frame_last = it.frame_end;
      pending.insert(pending.size(), exp_item);
    endfunction

    function void check_result(dffc_pkg::out_item_t got);
      dffc_pkg::out_item_t exp_item;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_item = pending.pop_front();
      if (got !== exp_item) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: pixel exp %0d got %0d, sat exp %0b got %0b, last exp %0b got %0b",
                   exp_item.corrected_pixel, got.corrected_pixel, exp_item.saturated,
                   got.saturated, exp_item.frame_last, got.frame_last);
      end
    endfunction
  endclass

  logic                           clk, rst;
  logic                           in_valid, in_stall, out_valid, out_stall;
  dffc_pkg::in_item_t             in_item;
  dffc_pkg::out_item_t            out_item;
  logic                           cfg_we;
  logic [dffc_pkg::CfgIndexW-1:0] cfg_index;
  logic [dffc_pkg::CfgDataW-1:0]  cfg_data;

  pixel_scoreboard sb;
  int  hold_off;     // receiver long stall request, in cycles
  bit  calm;         // no random idling while set

  detector_flat_field_correction_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("detector_flat_field_correction_top regression: fail");
    $finish;
  end

  // Receiver: random stalls plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_item);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 13);
      end
    end
  end

  // One register write, after which the enable is driven low again
  task automatic write_reg(logic [dffc_pkg::CfgIndexW-1:0] idx,
                           logic [dffc_pkg::CfgDataW-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Stops offering and waits for the pipeline to drain before any register change
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Offers one item and holds it until accepted
  task automatic send_item(dffc_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  function automatic logic [15:0] rand_pix();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(255));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic random_regs();
    write_reg(dffc_pkg::RegDarkEnable, DW'($urandom_range(1)));
    write_reg(dffc_pkg::RegGainEnable, DW'($urandom_range(1)));
    write_reg(dffc_pkg::RegDarkLoaded, DW'($urandom_range(7) != 0));
    write_reg(dffc_pkg::RegGainLoaded, DW'($urandom_range(7) != 0));
    case ($urandom_range(3))
      0: write_reg(dffc_pkg::RegGainMean, 24'hFFFFFF);
      1: write_reg(dffc_pkg::RegGainMean, 24'd0);
      default: write_reg(dffc_pkg::RegGainMean, DW'($urandom_range(24'hFFFFFF)));
    endcase
    case ($urandom_range(3))
      0: write_reg(dffc_pkg::RegCalibFactor, 24'h00FFFF);
      1: write_reg(dffc_pkg::RegCalibFactor, 24'd0);
      default: write_reg(dffc_pkg::RegCalibFactor, DW'($urandom_range(1023)));
    endcase
    write_reg(dffc_pkg::RegClampEnable, DW'($urandom_range(1)));
    write_reg(dffc_pkg::RegClampValue,
              ($urandom_range(3) == 0) ? 24'h00FFFF : DW'($urandom_range(65535)));
  endtask

  initial begin
    dffc_pkg::in_item_t it;
    int mode;
    sb = new();
    sb.reset_regs();
    rst = 1; in_valid = 0; in_item = '0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    hold_off = 0; calm = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: each mode with the fallbacks and extremes
    for (mode = 0; mode < 4; mode++) begin
      write_reg(dffc_pkg::RegDarkEnable, DW'(mode[0]));
      write_reg(dffc_pkg::RegGainEnable, DW'(mode[1]));
      write_reg(dffc_pkg::RegDarkLoaded, 24'd1);
      write_reg(dffc_pkg::RegGainLoaded, 24'd1);
      write_reg(dffc_pkg::RegGainMean, mode == 3 ? 24'hFFFFFF : 24'd1000 << 8);
      write_reg(dffc_pkg::RegCalibFactor, mode == 3 ? 24'h00FFFF : 24'd256);
      write_reg(dffc_pkg::RegClampEnable, DW'(mode == 2));
      write_reg(dffc_pkg::RegClampValue, 24'd40000);
      send_item('{16'hFFFF, 16'h0000, 16'hFFFF, 1'b0});
      send_item('{16'h0010, 16'h0020, 16'h0000, 1'b1});   // raw below dark, zero gain
      send_item('{16'h0100, 16'h0010, 16'h0008, 1'b0});   // gain not above dark
      send_item('{16'hFFFF, 16'h0001, 16'h0002, 1'b1});   // saturating quotient
      send_item('{16'h0000, 16'hFFFF, 16'hFFFF, 1'b0});
      drain();
    end
    // References missing: raw fallback, calibration still applied
    write_reg(dffc_pkg::RegDarkLoaded, 24'd0);
    write_reg(dffc_pkg::RegGainLoaded, 24'd0);
    send_item('{16'h1234, 16'h0034, 16'h0200, 1'b1});
    drain();
    write_reg(dffc_pkg::RegGainMean, 24'd0);   // zero mean on the divided path
    write_reg(dffc_pkg::RegDarkLoaded, 24'd1);
    write_reg(dffc_pkg::RegGainLoaded, 24'd1);
    send_item('{16'h1234, 16'h0034, 16'h0200, 1'b0});
    drain();

    // Random phases; one runs without idling, one under a long hold-off
    for (int ph = 0; ph < 15; ph++) begin
      random_regs();
      calm = (ph == 3);
      if (ph == 6) hold_off = 200;
      for (int k = 0; k < 100; k++) begin
        it.raw_pixel = rand_pix();
        it.dark_pixel = ($urandom_range(3) == 0) ? rand_pix() : 16'($urandom_range(4095));
        it.gain_pixel = rand_pix();
        it.frame_end = ($urandom_range(15) == 0);
        send_item(it);
      end
      calm = 0;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("detector_flat_field_correction_top regression: pass");
    else
      $display("detector_flat_field_correction_top regression: fail");
    $finish;
  end

endmodule

[sim.f]
rtl/dffc_pkg.sv
rtl/dffc_front.sv
rtl/dffc_queue.sv
rtl/dffc_back.sv
rtl/detector_flat_field_correction_top.sv
tb/tb.sv
